FILE: rtl/core/batch_log_record_deframer_unit_macros.svh
// assertion macros for the batch log record deframer checker
`ifndef BATCH_LOG_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define BATCH_LOG_RECORD_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BLD_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BLD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bld_pkg.sv
// shared types and constants of the batch log record deframer
package bld_pkg;

    localparam logic [31:0] MAX_COUNT_RESET = 32'd16777216;

    // header bytes, byte 0 in the low bits
    localparam logic [63:0] HDR_WORD = 64'h0A31_5742_4244_5453;

    localparam logic [3:0] CLS_HDR     = 4'd0;
    localparam logic [3:0] CLS_DCNT    = 4'd1;
    localparam logic [3:0] CLS_DKLEN   = 4'd2;
    localparam logic [3:0] CLS_DKEY    = 4'd3;
    localparam logic [3:0] CLS_PCNT    = 4'd4;
    localparam logic [3:0] CLS_PKLEN   = 4'd5;
    localparam logic [3:0] CLS_PKEY    = 4'd6;
    localparam logic [3:0] CLS_PVLEN   = 4'd7;
    localparam logic [3:0] CLS_PVAL    = 4'd8;
    localparam logic [3:0] CLS_IGNORED = 4'd9;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_HEADER     = 4'd1;
    localparam logic [3:0] ERR_DCNT_SHORT = 4'd2;
    localparam logic [3:0] ERR_DCNT_LARGE = 4'd3;
    localparam logic [3:0] ERR_DKLEN_SHORT = 4'd4;
    localparam logic [3:0] ERR_DKEY_TRUNC = 4'd5;
    localparam logic [3:0] ERR_PCNT_SHORT = 4'd6;
    localparam logic [3:0] ERR_PCNT_LARGE = 4'd7;
    localparam logic [3:0] ERR_PKLEN_SHORT = 4'd8;
    localparam logic [3:0] ERR_PKEY_TRUNC = 4'd9;
    localparam logic [3:0] ERR_PVLEN_SHORT = 4'd10;
    localparam logic [3:0] ERR_PVAL_TRUNC = 4'd11;
    localparam logic [3:0] ERR_TRAILING   = 4'd12;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] hdr_hit;
    } bld_item_t;

endpackage

FILE: rtl/core/bld_in_if.sv
// raw record byte channel
interface bld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/bld_out_if.sv
// tagged byte channel
interface bld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] byte_class;
    logic       field_end;
    logic       empty_field;
    logic [1:0] status;
    logic [3:0] error_code;

    modport source (
        output valid, output out_byte, output byte_class, output field_end,
        output empty_field, output status, output error_code, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_class, input field_end,
        input empty_field, input status, input error_code, output ready
    );
endinterface

FILE: rtl/core/bld_front.sv
// front end: takes input items and precomputes header byte matches
module bld_front
    import bld_pkg::*;
(
    bld_in_if.sink    record_bytes,
    input  logic      queue_full,
    output logic      push,
    output bld_item_t push_item
);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            push_item.hdr_hit[i] = (record_bytes.data_byte == HDR_WORD[8*i +: 8]);
        end
        push_item.data_byte = record_bytes.data_byte;
        push_item.last_byte = record_bytes.last_byte;
    end

    assign record_bytes.ready = !queue_full;
    assign push = record_bytes.valid && !queue_full;

endmodule

FILE: rtl/core/bld_queue.sv
// small queue between front end and parser
module bld_queue
    import bld_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bld_item_t push_item,
    input  logic      pop,
    output bld_item_t head,
    output logic      empty,
    output logic      full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bld_item_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/bld_back.sv
// parser: walks the record framing and drives the output register
module bld_back
    import bld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  bld_item_t   head,
    input  logic        empty,
    output logic        pop,
    bld_out_if.source   tagged_bytes
);

    typedef enum logic [3:0] {
        PH_HDR   = CLS_HDR,
        PH_DCNT  = CLS_DCNT,
        PH_DKLEN = CLS_DKLEN,
        PH_DKEY  = CLS_DKEY,
        PH_PCNT  = CLS_PCNT,
        PH_PKLEN = CLS_PKLEN,
        PH_PKEY  = CLS_PKEY,
        PH_PVLEN = CLS_PVLEN,
        PH_PVAL  = CLS_PVAL,
        PH_END   = CLS_IGNORED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] entries_reg, entries_next;
    logic [3:0]  err_reg, err_next;
    logic [31:0] max_count_reg;

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  class_reg, class_next;
    logic        fe_reg, fe_next;
    logic        ef_reg, ef_next;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  code_reg, code_next;

    logic [31:0] word;

    function automatic logic [3:0] short_code(input phase_t ph);
        case (ph)
            PH_HDR:   short_code = ERR_HEADER;
            PH_DCNT:  short_code = ERR_DCNT_SHORT;
            PH_DKLEN: short_code = ERR_DKLEN_SHORT;
            PH_DKEY:  short_code = ERR_DKEY_TRUNC;
            PH_PCNT:  short_code = ERR_PCNT_SHORT;
            PH_PKLEN: short_code = ERR_PKLEN_SHORT;
            PH_PKEY:  short_code = ERR_PKEY_TRUNC;
            PH_PVLEN: short_code = ERR_PVLEN_SHORT;
            PH_PVAL:  short_code = ERR_PVAL_TRUNC;
            default:  short_code = ERR_NONE;
        endcase
    endfunction

    assign pop  = !empty && (!valid_reg || tagged_bytes.ready);
    assign word = acc_reg | (32'(head.data_byte) << {pos_reg[1:0], 3'b000});

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        field_next   = field_reg;
        entries_next = entries_reg;
        err_next     = err_reg;
        class_next   = CLS_IGNORED;
        fe_next      = 1'b0;
        ef_next      = 1'b0;
        status_next  = ST_BUSY;
        code_next    = err_reg;

        if (err_reg == ERR_NONE)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    class_next = CLS_HDR;
                    if (!head.hdr_hit[pos_reg])
                    begin
                        err_next = ERR_HEADER;
                    end
                    else if (pos_reg == 3'd7)
                    begin
                        phase_next = PH_DCNT;
                        pos_next   = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                PH_DCNT, PH_DKLEN, PH_PCNT, PH_PKLEN, PH_PVLEN:
                begin
                    class_next = phase_reg;
                    acc_next   = word;
                    if (pos_reg < 3'd3)
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        fe_next  = 1'b1;
                        pos_next = '0;
                        acc_next = '0;
                        if (phase_reg == PH_DCNT || phase_reg == PH_PCNT)
                        begin
                            if (word > max_count_reg)
                            begin
                                err_next = (phase_reg == PH_DCNT) ? ERR_DCNT_LARGE
                                                                  : ERR_PCNT_LARGE;
                            end
                            else
                            begin
                                entries_next = word;
                                if (phase_reg == PH_DCNT)
                                begin
                                    phase_next = (word == '0) ? PH_PCNT : PH_DKLEN;
                                end
                                else
                                begin
                                    phase_next = (word == '0) ? PH_END : PH_PKLEN;
                                end
                            end
                        end
                        else if (word == '0)
                        begin
                            ef_next = 1'b1;
                            if (phase_reg == PH_PKLEN)
                            begin
                                phase_next = PH_PVLEN;
                            end
                            else
                            begin
                                entries_next = entries_reg - 32'd1;
                                if (phase_reg == PH_DKLEN)
                                begin
                                    phase_next = (entries_reg == 32'd1) ? PH_PCNT : PH_DKLEN;
                                end
                                else
                                begin
                                    phase_next = (entries_reg == 32'd1) ? PH_END : PH_PKLEN;
                                end
                            end
                        end
                        else
                        begin
                            field_next = word;
                            case (phase_reg)
                                PH_DKLEN: phase_next = PH_DKEY;
                                PH_PKLEN: phase_next = PH_PKEY;
                                default:  phase_next = PH_PVAL;
                            endcase
                        end
                    end
                end
                PH_DKEY, PH_PKEY, PH_PVAL:
                begin
                    class_next = phase_reg;
                    field_next = field_reg - 32'd1;
                    if (field_reg == 32'd1)
                    begin
                        fe_next  = 1'b1;
                        pos_next = '0;
                        acc_next = '0;
                        if (phase_reg == PH_PKEY)
                        begin
                            phase_next = PH_PVLEN;
                        end
                        else
                        begin
                            entries_next = entries_reg - 32'd1;
                            if (phase_reg == PH_DKEY)
                            begin
                                phase_next = (entries_reg == 32'd1) ? PH_PCNT : PH_DKLEN;
                            end
                            else
                            begin
                                phase_next = (entries_reg == 32'd1) ? PH_END : PH_PKLEN;
                            end
                        end
                    end
                end
                default:
                begin
                    err_next = ERR_TRAILING;
                end
            endcase
        end

        code_next = err_next;

        if (head.last_byte)
        begin
            if (err_next == ERR_NONE && phase_next != PH_END)
            begin
                code_next = short_code(phase_next);
            end
            status_next  = (code_next != ERR_NONE) ? ST_REJECT : ST_OK;
            phase_next   = PH_HDR;
            pos_next     = '0;
            acc_next     = '0;
            field_next   = '0;
            entries_next = '0;
            err_next     = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            pos_reg       <= '0;
            acc_reg       <= '0;
            field_reg     <= '0;
            entries_reg   <= '0;
            err_reg       <= ERR_NONE;
            max_count_reg <= MAX_COUNT_RESET;
            valid_reg     <= 1'b0;
            byte_reg      <= '0;
            class_reg     <= CLS_HDR;
            fe_reg        <= 1'b0;
            ef_reg        <= 1'b0;
            status_reg    <= ST_BUSY;
            code_reg      <= ERR_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                max_count_reg <= cfg_wdata;
            end
            if (pop)
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                acc_reg     <= acc_next;
                field_reg   <= field_next;
                entries_reg <= entries_next;
                err_reg     <= err_next;
                valid_reg   <= 1'b1;
                byte_reg    <= head.data_byte;
                class_reg   <= class_next;
                fe_reg      <= fe_next;
                ef_reg      <= ef_next;
                status_reg  <= status_next;
                code_reg    <= code_next;
            end
            else if (tagged_bytes.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign tagged_bytes.valid       = valid_reg;
    assign tagged_bytes.out_byte    = byte_reg;
    assign tagged_bytes.byte_class  = class_reg;
    assign tagged_bytes.field_end   = fe_reg;
    assign tagged_bytes.empty_field = ef_reg;
    assign tagged_bytes.status      = status_reg;
    assign tagged_bytes.error_code  = code_reg;

endmodule

FILE: rtl/core/batch_log_record_deframer_unit.sv
// top level of the batch log record deframer
// record_bytes carries one record byte per item with last_byte on the final one.
// tagged_bytes returns one item per input item: the byte, its class, field end
// and empty length marks, and on the last byte the status and error code.
// max_count is loaded through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, as the block does not enforce it. an accepted item enters
// a QUEUE_DEPTH entry queue; the parser takes the queue head and registers its
// result, so an item passes a queue entry and then the output register before
// it appears on tagged_bytes. throughput is one item per cycle while
// tagged_bytes is ready, set by the parser taking one queue entry per cycle
// into the output register. when tagged_bytes stalls, the output register holds
// and the queue fills; record_bytes.ready drops only when the queue is full.
// reset empties the queue, clears the output register and the record state,
// and sets max_count to 16777216. after each last byte the parser is back at
// the header and expects a new record.
module batch_log_record_deframer_unit
    import bld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    bld_in_if.sink      record_bytes,
    bld_out_if.source   tagged_bytes
);

    logic      push;
    bld_item_t push_item;
    logic      pop;
    bld_item_t head;
    logic      empty;
    logic      full;

    bld_front u_front (
        .record_bytes (record_bytes),
        .queue_full   (full),
        .push         (push),
        .push_item    (push_item)
    );

    bld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    bld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .tagged_bytes (tagged_bytes)
    );

endmodule

FILE: rtl/core/bld_checker.sv
// port-level checks for the batch log record deframer, bound to the top level
`include "batch_log_record_deframer_unit_macros.svh"

module bld_checker
    import bld_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [3:0] byte_class,
    input logic       field_end,
    input logic       empty_field,
    input logic [1:0] status,
    input logic [3:0] error_code
);

    logic       out_acc;
    logic       held_err_reg;
    logic [3:0] prev_err_reg;

    assign out_acc = out_valid && out_ready;

    // error seen mid-record must persist to the end of the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_err_reg <= 1'b0;
            prev_err_reg <= ERR_NONE;
        end
        else if (out_acc)
        begin
            held_err_reg <= (status == ST_BUSY) && (error_code != ERR_NONE);
            prev_err_reg <= error_code;
        end
    end

    `BLD_CHECK_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(byte_class) && $stable(status)
        && $stable(error_code), "output item changed while stalled")

    `BLD_CHECK_NOW(a_empty_on_len, out_valid && empty_field,
        field_end && (byte_class == CLS_DKLEN || byte_class == CLS_PKLEN
        || byte_class == CLS_PVLEN), "empty mark off a length word end")

    `BLD_CHECK_NOW(a_err_sticky, out_acc && held_err_reg,
        error_code == prev_err_reg && byte_class == CLS_IGNORED && !field_end,
        "latched error lost or byte not ignored")

    `BLD_CHECK_NOW(a_ok_no_err, out_valid && status == ST_OK,
        error_code == ERR_NONE, "record reported ok with an error")

endmodule

bind batch_log_record_deframer_unit bld_checker u_bld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tagged_bytes.valid),
    .out_ready   (tagged_bytes.ready),
    .out_byte    (tagged_bytes.out_byte),
    .byte_class  (tagged_bytes.byte_class),
    .field_end   (tagged_bytes.field_end),
    .empty_field (tagged_bytes.empty_field),
    .status      (tagged_bytes.status),
    .error_code  (tagged_bytes.error_code)
);
